// ===== hw/rtl/http_status_line_parser_macros.svh =====
// assertion macros for the status line parser
`ifndef HTTP_STATUS_LINE_PARSER_MACROS_SVH
`define HTTP_STATUS_LINE_PARSER_MACROS_SVH

// same-cycle implication
`define HSLP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("status line parser check failed");

// next-cycle implication
`define HSLP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("status line parser check failed");

`endif

// ===== hw/rtl/hslp_pkg.sv =====
// types, codes and character helpers for the status line parser
package hslp_pkg;

    localparam int MAX_CODE_DIGITS_DEF = 3;
    localparam int MIN_CODE_DIGITS     = 3;
    localparam int CODE_LIMIT          = 999;
    localparam logic [11:0] MSG_LEN_RESET = 12'd1024;

    localparam logic [7:0] CH_H_UP  = 8'h48;
    localparam logic [7:0] CH_H_LO  = 8'h68;
    localparam logic [7:0] CH_T_UP  = 8'h54;
    localparam logic [7:0] CH_T_LO  = 8'h74;
    localparam logic [7:0] CH_P_UP  = 8'h50;
    localparam logic [7:0] CH_P_LO  = 8'h70;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [3:0] {
        ST_NAME0 = 4'd0,
        ST_NAME1 = 4'd1,
        ST_NAME2 = 4'd2,
        ST_NAME3 = 4'd3,
        ST_NAME4 = 4'd4,
        ST_MAJOR = 4'd5,
        ST_DOT   = 4'd6,
        ST_MINOR = 4'd7,
        ST_SP1   = 4'd8,
        ST_CODE  = 4'd9,
        ST_MSG   = 4'd10,
        ST_CR    = 4'd11,
        ST_DONE  = 4'd12,
        ST_ERR   = 4'd13
    } state_t;

    typedef enum logic [3:0] {
        EV_WAIT     = 4'd0,
        EV_NAME     = 4'd1,
        EV_MAJOR    = 4'd2,
        EV_MINOR    = 4'd3,
        EV_CODE     = 4'd4,
        EV_CODE_END = 4'd5,
        EV_MSG      = 4'd6,
        EV_DONE     = 4'd7,
        EV_UNEXP    = 4'd8
    } event_t;

    typedef enum logic [1:0] {
        LS_PARSING = 2'd0,
        LS_OK      = 2'd1,
        LS_BAD     = 2'd2
    } line_status_t;

    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] in_byte;
    } hslp_in_t;

    typedef struct packed {
        event_t       event_res;
        logic [7:0]   echo_byte;
        line_status_t line_status;
        logic [3:0]   major_version;
        logic [3:0]   minor_version;
        logic [9:0]   code_value;
        logic [11:0]  message_count;
    } hslp_out_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // rfc 2046 bchars
    function automatic logic is_bchar(input logic [7:0] c);
        logic ok;
        ok = is_digit(c)
            || ((c >= 8'h41) && (c <= 8'h5a))
            || ((c >= 8'h61) && (c <= 8'h7a));
        case (c)
            8'h20, 8'h27, 8'h28, 8'h29, 8'h2b, 8'h5f,
            8'h2c, 8'h2d, 8'h2e, 8'h2f, 8'h3a, 8'h3d, 8'h3f: ok = 1'b1;
            default: ;
        endcase
        return ok;
    endfunction

endpackage

// ===== hw/rtl/http_status_line_parser.sv =====
// status line parser: one byte per beat, one result beat per byte
//
// channel  direction  payload      handshake
// byte     in         hslp_in_t    byte_valid / byte_ready
// res      out        hslp_out_t   res_valid  / res_ready
// cfg      in         12-bit data  cfg_valid  / cfg_ready
//
// one byte per cycle while res_ready is high; the result appears in the cycle after its byte is taken
// the parse state and result register set the pace, no other loop
// byte_ready drops only while a result is held and res_ready is low
// reset: start state, all captured values zero, message limit 1024
// cfg_ready is always high
`include "http_status_line_parser_macros.svh"

module http_status_line_parser
    import hslp_pkg::*;
#(
    parameter int MAX_CODE_DIGITS = MAX_CODE_DIGITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  hslp_in_t    byte_beat,
    output logic        res_valid,
    input  logic        res_ready,
    output hslp_out_t   res_beat,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [11:0] cfg_data
);

    localparam int CntW = $clog2(MAX_CODE_DIGITS + 1);

    state_t          state_reg, state_next;
    logic [3:0]      major_reg, major_next;
    logic [3:0]      minor_reg, minor_next;
    logic [9:0]      code_reg, code_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [11:0]     msg_len_reg, msg_len_next;
    logic [11:0]     max_len_reg;
    logic            res_valid_reg;
    hslp_out_t       res_beat_reg, res_beat_next;

    logic            accept;
    logic [7:0]      c;
    logic            restart;
    event_t          ev;
    line_status_t    status;
    logic [13:0]     code_prod;

    assign accept     = byte_valid && byte_ready;
    assign byte_ready = !res_valid_reg || res_ready;
    assign cfg_ready  = 1'b1;
    assign res_valid  = res_valid_reg;
    assign res_beat   = res_beat_reg;
    assign c          = byte_beat.in_byte;
    assign restart    = (byte_beat.kind == KIND_RESTART);
    assign code_prod  = {1'b0, code_reg, 3'b000} + {3'b000, code_reg, 1'b0}
                      + {10'd0, c[3:0]};

    // event classification
    always_comb
    begin
        ev = EV_UNEXP;
        if (restart)
        begin
            ev = EV_WAIT;
        end
        else
        begin
            unique case (state_reg)
                ST_NAME0: if (c == CH_H_UP || c == CH_H_LO) ev = EV_NAME;
                ST_NAME1: if (c == CH_T_UP || c == CH_T_LO) ev = EV_NAME;
                ST_NAME2: if (c == CH_T_UP || c == CH_T_LO) ev = EV_NAME;
                ST_NAME3: if (c == CH_P_UP || c == CH_P_LO) ev = EV_NAME;
                ST_NAME4: if (c == CH_SLASH) ev = EV_NAME;
                ST_MAJOR: if (is_digit(c)) ev = EV_MAJOR;
                ST_DOT:   if (c == CH_DOT) ev = EV_WAIT;
                ST_MINOR: if (is_digit(c)) ev = EV_MINOR;
                ST_SP1:   if (c == CH_SPACE) ev = EV_WAIT;
                ST_CODE:
                begin
                    if (is_digit(c))
                    begin
                        if (cnt_reg < CntW'(MAX_CODE_DIGITS))
                            ev = EV_CODE;
                    end
                    else if (c == CH_SPACE && cnt_reg >= CntW'(MIN_CODE_DIGITS))
                    begin
                        ev = EV_CODE_END;
                    end
                end
                ST_MSG:
                begin
                    if (is_bchar(c))
                    begin
                        if (msg_len_reg < max_len_reg)
                            ev = EV_MSG;
                    end
                    else if (c == CH_CR)
                    begin
                        ev = EV_WAIT;
                    end
                end
                ST_CR:    if (c == CH_LF) ev = EV_DONE;
                default:  ev = EV_UNEXP;
            endcase
        end
        status = LS_PARSING;
        if (!restart && ev == EV_UNEXP)
            status = LS_BAD;
        else if (!restart && ev == EV_DONE)
            status = LS_OK;
    end

    // next state
    always_comb
    begin
        state_next = ST_ERR;
        if (restart)
        begin
            state_next = ST_NAME0;
        end
        else if (ev != EV_UNEXP)
        begin
            unique case (state_reg)
                ST_NAME0: state_next = ST_NAME1;
                ST_NAME1: state_next = ST_NAME2;
                ST_NAME2: state_next = ST_NAME3;
                ST_NAME3: state_next = ST_NAME4;
                ST_NAME4: state_next = ST_MAJOR;
                ST_MAJOR: state_next = ST_DOT;
                ST_DOT:   state_next = ST_MINOR;
                ST_MINOR: state_next = ST_SP1;
                ST_SP1:   state_next = ST_CODE;
                ST_CODE:  state_next = (ev == EV_CODE) ? ST_CODE : ST_MSG;
                ST_MSG:   state_next = (ev == EV_MSG) ? ST_MSG : ST_CR;
                ST_CR:    state_next = ST_DONE;
                default:  state_next = ST_ERR;
            endcase
        end
    end

    // captured values and result beat
    always_comb
    begin
        major_next   = major_reg;
        minor_next   = minor_reg;
        code_next    = code_reg;
        cnt_next     = cnt_reg;
        msg_len_next = msg_len_reg;
        if (restart)
        begin
            major_next   = '0;
            minor_next   = '0;
            code_next    = '0;
            cnt_next     = '0;
            msg_len_next = '0;
        end
        else
        begin
            case (ev)
                EV_MAJOR: major_next = c[3:0];
                EV_MINOR: minor_next = c[3:0];
                EV_CODE:
                begin
                    code_next = (code_prod > 14'(CODE_LIMIT)) ? 10'(CODE_LIMIT)
                                                              : code_prod[9:0];
                    cnt_next  = cnt_reg + CntW'(1);
                end
                EV_MSG:   msg_len_next = msg_len_reg + 12'd1;
                default: ;
            endcase
        end
        res_beat_next.event_res     = ev;
        res_beat_next.echo_byte     = restart ? 8'd0 : c;
        res_beat_next.line_status   = status;
        res_beat_next.major_version = major_next;
        res_beat_next.minor_version = minor_next;
        res_beat_next.code_value    = code_next;
        res_beat_next.message_count = msg_len_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_NAME0;
            major_reg     <= '0;
            minor_reg     <= '0;
            code_reg      <= '0;
            cnt_reg       <= '0;
            msg_len_reg   <= '0;
            max_len_reg   <= MSG_LEN_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                max_len_reg <= cfg_data;
            if (accept)
            begin
                state_reg   <= state_next;
                major_reg   <= major_next;
                minor_reg   <= minor_next;
                code_reg    <= code_next;
                cnt_reg     <= cnt_next;
                msg_len_reg <= msg_len_next;
            end
            if (accept)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_beat_reg <= res_beat_next;
    end

    `HSLP_ASSERT_NEXT(a_restart_clears, accept && restart,
        state_reg == ST_NAME0 && code_reg == 10'd0 && msg_len_reg == 12'd0 && cnt_reg == '0)
    `HSLP_ASSERT_NEXT(a_closed_line_unexp,
        accept && !restart && (state_reg == ST_DONE || state_reg == ST_ERR),
        res_beat_reg.event_res == EV_UNEXP && res_beat_reg.line_status == LS_BAD)
    `HSLP_ASSERT_NOW(a_digit_count_bound, 1'b1, cnt_reg <= CntW'(MAX_CODE_DIGITS))
    `HSLP_ASSERT_NEXT(a_accept_gives_result, accept, res_valid_reg)

endmodule
